[design/assert_macros.svh]
// Assertion macros shared by the lexer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define CTL_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define CTL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[design/ctl_pkg.sv]
// Shared types, codes and helpers of the C token lexer.
package ctl_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [2:0] KIND_END   = 3'd0;
   localparam logic [2:0] KIND_NUM   = 3'd1;
   localparam logic [2:0] KIND_IDENT = 3'd2;
   localparam logic [2:0] KIND_STR   = 3'd3;
   localparam logic [2:0] KIND_CHR   = 3'd4;
   localparam logic [2:0] KIND_PUNCT = 3'd5;

   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_STR_OPEN   = 3'd1;
   localparam logic [2:0] ERR_ESC_END    = 3'd2;
   localparam logic [2:0] ERR_ESC_BAD    = 3'd3;
   localparam logic [2:0] ERR_CHR_BAD    = 3'd4;
   localparam logic [2:0] ERR_CHR_OPEN   = 3'd5;
   localparam logic [2:0] ERR_UNEXPECTED = 3'd6;
   localparam logic [2:0] ERR_COMMENT    = 3'd7;

   localparam logic [8:0] PAIR_INC   = 9'd256;
   localparam logic [8:0] PAIR_DEC   = 9'd257;
   localparam logic [8:0] PAIR_ARROW = 9'd258;
   localparam logic [8:0] PAIR_EQ    = 9'd259;
   localparam logic [8:0] PAIR_AND   = 9'd260;
   localparam logic [8:0] PAIR_OR    = 9'd261;
   localparam logic [8:0] PAIR_SHL   = 9'd262;
   localparam logic [8:0] PAIR_SHR   = 9'd263;

   localparam logic [7:0] CH_DOT       = 8'h2e;
   localparam logic [7:0] CH_UNDER     = 8'h5f;
   localparam logic [7:0] CH_N         = 8'h6e;
   localparam logic [7:0] CH_QUOTE     = 8'h27;
   localparam logic [7:0] CH_BACKSLASH = 8'h5c;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_SLASH     = 8'h2f;
   localparam logic [7:0] CH_STAR      = 8'h2a;
   localparam logic [7:0] CH_NEWLINE   = 8'h0a;
   localparam logic [7:0] CH_MINUS     = 8'h2d;
   localparam logic [7:0] CH_GT        = 8'h3e;

   typedef enum logic [3:0] {
      LEX_IDLE,
      LEX_NUM,
      LEX_IDENT,
      LEX_STR,
      LEX_STR_ESC,
      LEX_CHR_OPEN,
      LEX_CHR_ESC,
      LEX_CHR_BYTE,
      LEX_SLASH,
      LEX_LINE,
      LEX_BLOCK,
      LEX_BLOCK_STAR,
      LEX_REP,
      LEX_ERR
   } lex_state_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [8:0] value;
      logic       has_char;
      logic       token_first;
      logic       token_last;
      logic [2:0] error_code;
   } result_type;

   typedef struct packed {
      logic       two;
      result_type r0;
      result_type r1;
   } entry_type;

   typedef struct packed {
      logic          emit;
      result_type    res;
      lex_state_type nxt;
      logic          hold;
      logic [7:0]    held;
   } idle_out_type;

   function automatic result_type mk_result(logic [2:0] kind, logic [8:0] value,
                                            logic has_char, logic first, logic last,
                                            logic [2:0] err);
      result_type r;
      r.kind        = kind;
      r.value       = value;
      r.has_char    = has_char;
      r.token_first = first;
      r.token_last  = last;
      r.error_code  = err;
      return r;
   endfunction

   function automatic result_type err_result(logic [2:0] err);
      return mk_result(KIND_END, 9'd0, 1'b0, 1'b0, 1'b0, err);
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
   endfunction

   function automatic logic is_space(logic [7:0] c);
      return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
   endfunction

   function automatic logic [8:0] pair_code(logic [7:0] c);
      logic [8:0] code;
      case (c)
         8'h2b: code = PAIR_INC;
         8'h2d: code = PAIR_DEC;
         8'h3d: code = PAIR_EQ;
         8'h26: code = PAIR_AND;
         8'h7c: code = PAIR_OR;
         8'h3c: code = PAIR_SHL;
         default: code = PAIR_SHR;
      endcase
      return code;
   endfunction

endpackage

[design/ctl_front.sv]
// Lexer front: accepts source beats, runs the character state machine, pushes results.
`include "assert_macros.svh"

module ctl_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_ch,
   input  logic               req_end_of_input,
   input  logic               q_full,
   output logic               q_push,
   output ctl_pkg::entry_type q_wdata
);
   import ctl_pkg::*;

   lex_state_type state_ff, state_in;
   logic [7:0]    held_ff, held_in;
   logic          accept;
   logic          pre_valid, use_idle;
   result_type    pre_res;
   idle_out_type  id;
   logic [7:0]    c;
   logic          eoi;

   function automatic idle_out_type idle_take(logic [7:0] ch, logic end_in);
      idle_out_type o;
      o.emit = 1'b0;
      o.res  = err_result(ERR_NONE);
      o.nxt  = LEX_IDLE;
      o.hold = 1'b0;
      o.held = ch;
      if (end_in) begin
         o.emit = 1'b1;
         o.res  = mk_result(KIND_END, 9'd0, 1'b0, 1'b1, 1'b1, ERR_NONE);
      end else if (is_space(ch)) begin
         o.emit = 1'b0;
      end else if (is_digit(ch)) begin
         o.emit = 1'b1;
         o.nxt  = LEX_NUM;
         o.res  = mk_result(KIND_NUM, {1'b0, ch}, 1'b1, 1'b1, 1'b0, ERR_NONE);
      end else if (is_alpha(ch) || ch == CH_UNDER) begin
         o.emit = 1'b1;
         o.nxt  = LEX_IDENT;
         o.res  = mk_result(KIND_IDENT, {1'b0, ch}, 1'b1, 1'b1, 1'b0, ERR_NONE);
      end else if (ch == CH_SLASH) begin
         o.nxt = LEX_SLASH;
      end else if (ch inside {8'h2a, 8'h28, 8'h29, 8'h2c, 8'h3b, 8'h2e, 8'h5b, 8'h5d,
                              8'h7b, 8'h7d, 8'h21, 8'h3f, 8'h3a}) begin
         o.emit = 1'b1;
         o.res  = mk_result(KIND_PUNCT, {1'b0, ch}, 1'b1, 1'b1, 1'b1, ERR_NONE);
      end else if (ch inside {8'h2d, 8'h3d, 8'h2b, 8'h26, 8'h7c, 8'h3c, 8'h3e}) begin
         o.nxt  = LEX_REP;
         o.hold = 1'b1;
      end else if (ch == CH_DQUOTE) begin
         o.emit = 1'b1;
         o.nxt  = LEX_STR;
         o.res  = mk_result(KIND_STR, 9'd0, 1'b0, 1'b1, 1'b0, ERR_NONE);
      end else if (ch == CH_QUOTE) begin
         o.nxt = LEX_CHR_OPEN;
      end else begin
         o.emit = 1'b1;
         o.nxt  = LEX_ERR;
         o.hold = 1'b1;
         o.held = {5'd0, ERR_UNEXPECTED};
         o.res  = err_result(ERR_UNEXPECTED);
      end
      return o;
   endfunction

   assign c         = req_ch;
   assign eoi       = req_end_of_input;
   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in  = state_ff;
      held_in   = held_ff;
      pre_valid = 1'b0;
      pre_res   = err_result(ERR_NONE);
      use_idle  = 1'b0;
      id        = idle_take(c, eoi);
      case (state_ff)
         LEX_ERR: begin
            pre_valid = 1'b1;
            pre_res   = err_result(held_ff[2:0]);
         end
         LEX_NUM, LEX_IDENT: begin
            pre_valid = 1'b1;
            if (!eoi && (is_digit(c) || is_alpha(c) ||
                         (state_ff == LEX_NUM ? c == CH_DOT : c == CH_UNDER))) begin
               pre_res = mk_result(state_ff == LEX_NUM ? KIND_NUM : KIND_IDENT,
                                   {1'b0, c}, 1'b1, 1'b0, 1'b0, ERR_NONE);
            end else begin
               pre_res  = mk_result(state_ff == LEX_NUM ? KIND_NUM : KIND_IDENT,
                                    9'd0, 1'b0, 1'b0, 1'b1, ERR_NONE);
               use_idle = 1'b1;
            end
         end
         LEX_STR: begin
            if (eoi) begin
               pre_valid = 1'b1;
               pre_res   = err_result(ERR_STR_OPEN);
               state_in  = LEX_ERR;
               held_in   = {5'd0, ERR_STR_OPEN};
            end else if (c == CH_DQUOTE) begin
               pre_valid = 1'b1;
               pre_res   = mk_result(KIND_STR, 9'd0, 1'b0, 1'b0, 1'b1, ERR_NONE);
               state_in  = LEX_IDLE;
            end else if (c == CH_BACKSLASH) begin
               state_in = LEX_STR_ESC;
            end else begin
               pre_valid = 1'b1;
               pre_res   = mk_result(KIND_STR, {1'b0, c}, 1'b1, 1'b0, 1'b0, ERR_NONE);
            end
         end
         LEX_STR_ESC: begin
            pre_valid = 1'b1;
            if (eoi) begin
               pre_res  = err_result(ERR_ESC_END);
               state_in = LEX_ERR;
               held_in  = {5'd0, ERR_ESC_END};
            end else if (c == CH_DQUOTE) begin
               pre_res  = mk_result(KIND_STR, {1'b0, c}, 1'b1, 1'b0, 1'b0, ERR_NONE);
               state_in = LEX_STR;
            end else if (c == CH_N) begin
               pre_res  = mk_result(KIND_STR, {1'b0, CH_NEWLINE}, 1'b1, 1'b0, 1'b0,
                                    ERR_NONE);
               state_in = LEX_STR;
            end else begin
               pre_res  = err_result(ERR_ESC_BAD);
               state_in = LEX_ERR;
               held_in  = {5'd0, ERR_ESC_BAD};
            end
         end
         LEX_CHR_OPEN, LEX_CHR_ESC: begin
            if (eoi) begin
               pre_valid = 1'b1;
               pre_res   = err_result(ERR_CHR_OPEN);
               state_in  = LEX_ERR;
               held_in   = {5'd0, ERR_CHR_OPEN};
            end else if (state_ff == LEX_CHR_OPEN && c == CH_BACKSLASH) begin
               state_in = LEX_CHR_ESC;
            end else begin
               held_in  = c;
               state_in = LEX_CHR_BYTE;
            end
         end
         LEX_CHR_BYTE: begin
            pre_valid = 1'b1;
            if (eoi) begin
               pre_res  = err_result(ERR_CHR_OPEN);
               state_in = LEX_ERR;
               held_in  = {5'd0, ERR_CHR_OPEN};
            end else if (c == CH_QUOTE) begin
               pre_res  = mk_result(KIND_CHR, {1'b0, held_ff}, 1'b1, 1'b1, 1'b1, ERR_NONE);
               state_in = LEX_IDLE;
            end else begin
               pre_res  = err_result(ERR_CHR_BAD);
               state_in = LEX_ERR;
               held_in  = {5'd0, ERR_CHR_BAD};
            end
         end
         LEX_SLASH: begin
            if (!eoi && c == CH_SLASH) begin
               state_in = LEX_LINE;
            end else if (!eoi && c == CH_STAR) begin
               state_in = LEX_BLOCK;
            end else begin
               pre_valid = 1'b1;
               pre_res   = mk_result(KIND_PUNCT, {1'b0, CH_SLASH}, 1'b1, 1'b1, 1'b1,
                                     ERR_NONE);
               use_idle  = 1'b1;
            end
         end
         LEX_LINE: begin
            if (eoi) begin
               use_idle = 1'b1;
            end else if (c == CH_NEWLINE) begin
               state_in = LEX_IDLE;
            end
         end
         LEX_BLOCK, LEX_BLOCK_STAR: begin
            if (eoi) begin
               pre_valid = 1'b1;
               pre_res   = err_result(ERR_COMMENT);
               state_in  = LEX_ERR;
               held_in   = {5'd0, ERR_COMMENT};
            end else if (c == CH_STAR) begin
               state_in = LEX_BLOCK_STAR;
            end else if (state_ff == LEX_BLOCK_STAR && c == CH_SLASH) begin
               state_in = LEX_IDLE;
            end else begin
               state_in = LEX_BLOCK;
            end
         end
         LEX_REP: begin
            pre_valid = 1'b1;
            if (!eoi && c == held_ff) begin
               pre_res  = mk_result(KIND_PUNCT, pair_code(held_ff), 1'b1, 1'b1, 1'b1,
                                    ERR_NONE);
               state_in = LEX_IDLE;
            end else if (!eoi && held_ff == CH_MINUS && c == CH_GT) begin
               pre_res  = mk_result(KIND_PUNCT, PAIR_ARROW, 1'b1, 1'b1, 1'b1, ERR_NONE);
               state_in = LEX_IDLE;
            end else begin
               pre_res  = mk_result(KIND_PUNCT, {1'b0, held_ff}, 1'b1, 1'b1, 1'b1,
                                    ERR_NONE);
               use_idle = 1'b1;
            end
         end
         default: begin
            use_idle = 1'b1;
         end
      endcase
      if (use_idle) begin
         state_in = id.nxt;
         if (id.hold) begin
            held_in = id.held;
         end
      end
      q_wdata.two = pre_valid && use_idle && id.emit;
      q_wdata.r0  = pre_valid ? pre_res : id.res;
      q_wdata.r1  = id.res;
      q_push      = accept && (pre_valid || (use_idle && id.emit));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LEX_IDLE;
         held_ff  <= 8'd0;
      end else if (accept) begin
         state_ff <= state_in;
         held_ff  <= held_in;
      end
   end

   `CTL_ASSERT(a_err_sticky, clock, reset, state_ff == LEX_ERR |=> state_ff == LEX_ERR, "error state left before reset")

endmodule

[design/ctl_queue.sv]
// Result queue between lexer front and back, with a registered head entry.
`include "assert_macros.svh"

module ctl_queue #(
   parameter int DEPTH = ctl_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ctl_pkg::entry_type wdata,
   output logic               full,
   output logic               head_valid,
   output ctl_pkg::entry_type head,
   input  logic               pop
);
   import ctl_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   entry_type       mem [DEPTH];
   logic [PW-1:0]   rd_ff, wr_ff;
   logic [CW-1:0]   count_ff;
   logic            head_valid_ff;
   entry_type       head_ff;
   logic            load, from_mem, bypass, to_mem;

   assign full       = count_ff == CW'(DEPTH);
   assign head_valid = head_valid_ff;
   assign head       = head_ff;
   assign load       = !head_valid_ff || pop;
   assign from_mem   = load && (count_ff != '0);
   assign bypass     = load && (count_ff == '0) && push;
   assign to_mem     = push && !bypass;

   always_ff @(posedge clock) begin
      if (to_mem) begin
         mem[wr_ff] <= wdata;
      end
      if (from_mem) begin
         head_ff <= mem[rd_ff];
      end else if (bypass) begin
         head_ff <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff         <= '0;
         wr_ff         <= '0;
         count_ff      <= '0;
         head_valid_ff <= 1'b0;
      end else begin
         if (to_mem) begin
            wr_ff <= (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (from_mem) begin
            rd_ff <= (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         if (to_mem && !from_mem) begin
            count_ff <= count_ff + 1'b1;
         end else if (from_mem && !to_mem) begin
            count_ff <= count_ff - 1'b1;
         end
         if (load) begin
            head_valid_ff <= from_mem || bypass;
         end
      end
   end

   `CTL_ASSERT(a_count_range, clock, reset, count_ff <= CW'(DEPTH), "queue count overflow")
   `CTL_ASSERT(a_empty_ptrs, clock, reset, count_ff == '0 |-> rd_ff == wr_ff, "empty queue with skewed pointers")

endmodule

[design/ctl_back.sv]
// Lexer back: drains queued entries one result per beat and marks the run end.
`include "assert_macros.svh"

module ctl_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  ctl_pkg::entry_type head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_kind,
   output logic [8:0]         rsp_value,
   output logic               rsp_has_char,
   output logic               rsp_token_first,
   output logic               rsp_token_last,
   output logic [2:0]         rsp_error_code,
   output logic               rsp_run_end
);
   import ctl_pkg::*;

   logic       slot_ff;
   result_type cur;
   logic       last_beat;

   assign cur             = slot_ff ? head.r1 : head.r0;
   assign last_beat       = slot_ff || !head.two;
   assign rsp_valid       = head_valid;
   assign rsp_kind        = cur.kind;
   assign rsp_value       = cur.value;
   assign rsp_has_char    = cur.has_char;
   assign rsp_token_first = cur.token_first;
   assign rsp_token_last  = cur.token_last;
   assign rsp_error_code  = cur.error_code;
   assign rsp_run_end     = last_beat;
   assign pop             = head_valid && rsp_ready && last_beat;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= 1'b0;
      end else if (head_valid && rsp_ready) begin
         slot_ff <= !last_beat;
      end
   end

   `CTL_ASSERT(a_second_slot, clock, reset, slot_ff |-> head_valid && head.two, "second result selected without a pair")

endmodule

[design/c_token_lexer.sv]
// Top level of the streaming C token lexer.
// Takes one source byte (or end-of-input mark) per req_ beat and emits tokens as rsp_ beats.
// An input beat is accepted every cycle while the result queue has room; a byte that causes
// two results (a token close followed by the start of the next) gives two rsp_ beats, so
// sustained rate is one byte per clock if each byte yields at most one result and rsp_ready
// is high. The front-stage character state machine sets the per-byte path; QUEUE_DEPTH
// entries plus one head register decouple it from rsp_ready. Errors stick until reset.
module c_token_lexer #(
   parameter int QUEUE_DEPTH = ctl_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_ch,
   input  logic       req_end_of_input,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_kind,
   output logic [8:0] rsp_value,
   output logic       rsp_has_char,
   output logic       rsp_token_first,
   output logic       rsp_token_last,
   output logic [2:0] rsp_error_code,
   output logic       rsp_run_end
);
   import ctl_pkg::*;

   logic      q_push, q_full, head_valid, pop;
   entry_type q_wdata, head;

   ctl_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_ch           (req_ch),
      .req_end_of_input (req_end_of_input),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_wdata          (q_wdata)
   );

   ctl_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .wdata      (q_wdata),
      .full       (q_full),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop)
   );

   ctl_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_value       (rsp_value),
      .rsp_has_char    (rsp_has_char),
      .rsp_token_first (rsp_token_first),
      .rsp_token_last  (rsp_token_last),
      .rsp_error_code  (rsp_error_code),
      .rsp_run_end     (rsp_run_end)
   );

endmodule
